// ===== src/fcc_pkg.sv =====
// fcc_pkg: shared types, codes and constants of the cluster chain engine.
// Used by fcc_table, fcc_ctrl and fat_cluster_chain_engine; no dependencies.
`default_nettype none

package fcc_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 65536;
   localparam int IDX_W = 16;
   localparam int VAL_W = 32;
   localparam int CNT_W = 17;
   localparam int STATUS_W = 3;
   localparam int CFG_RESET = 65536;

   localparam logic [VAL_W-1:0] FREE_MARK    = 32'h0000_0000;
   localparam logic [VAL_W-1:0] END_OF_CHAIN = 32'h0FFF_FFFF;
   localparam logic [VAL_W-1:0] CHAIN_LIMIT  = 32'h0FFF_FFF8;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_ALLOC = 2'd2,
      CMD_FREE  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_BAD_INDEX  = 3'd2,
      ST_BROKEN     = 3'd3,
      ST_ZERO_COUNT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_READ  = 3'd1,
      S_SCAN  = 3'd2,
      S_LINK  = 3'd3,
      S_TAIL  = 3'd4,
      S_CHECK = 3'd5,
      S_CLEAR = 3'd6,
      S_DONE  = 3'd7
   } state_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
      status_type       status;
   } result_type;

endpackage

`default_nettype wire

// ===== src/fat_cluster_chain_engine.sv =====
// fat_cluster_chain_engine: FAT32 cluster chain allocator top level.
// Depends on fcc_pkg, fcc_table and fcc_ctrl; holds the size register and result register.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_stall   cmd, index, entry_value, cluster_count
//   rsp_     out        rsp_valid / rsp_stall   value, count, status
//   csr_     in         csr_valid / csr_ready   entries_in_use
//
// One item at a time. Allocate scans the table for free entries and then links
// them into a chain; free walks the chain to its end and then clears it, one table
// read per cycle through the single read port. A waiting result sits in the output
// register while the next transfer is taken. Synchronous reset clears control
// state; table contents stay undefined until written.
`default_nettype none

module fat_cluster_chain_engine #(
   parameter int TABLE_ENTRIES = fcc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic [fcc_pkg::IDX_W-1:0]    req_index,
   input  wire logic [fcc_pkg::VAL_W-1:0]    req_entry_value,
   input  wire logic [fcc_pkg::CNT_W-1:0]    req_cluster_count,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [fcc_pkg::VAL_W-1:0]         rsp_value,
   output logic [fcc_pkg::CNT_W-1:0]         rsp_count,
   output logic [fcc_pkg::STATUS_W-1:0]      rsp_status,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [fcc_pkg::CNT_W-1:0]    csr_entries_in_use
);
   import fcc_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int LIM_RESET = (TABLE_ENTRIES < CFG_RESET) ? TABLE_ENTRIES : CFG_RESET;

   logic [CNT_W-1:0] lim_ff, lim_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   logic             res_valid;
   logic             res_take;
   result_type       res;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [VAL_W-1:0] mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [VAL_W-1:0] mem_rd_data;

   always_comb begin
      lim_in = lim_ff;
      if (csr_valid) begin
         if (32'(csr_entries_in_use) > 32'(TABLE_ENTRIES)) begin
            lim_in = CNT_W'(TABLE_ENTRIES);
         end else begin
            lim_in = csr_entries_in_use;
         end
      end
   end

   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff       <= CNT_W'(LIM_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   fcc_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AW            (AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .lim               (lim_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_entry_value   (req_entry_value),
      .req_cluster_count (req_cluster_count),
      .res_valid         (res_valid),
      .res_take          (res_take),
      .res               (res),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   fcc_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .AW            (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_ff.value;
   assign rsp_count  = rsp_ff.count;
   assign rsp_status = rsp_ff.status;

endmodule

`default_nettype wire

// ===== src/fcc_table.sv =====
// fcc_table: allocation table storage, one write port and one registered read port.
// Depends on fcc_pkg for the entry width.
`default_nettype none

module fcc_table #(
   parameter int TABLE_ENTRIES = fcc_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int AW = $clog2(TABLE_ENTRIES)
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic [fcc_pkg::VAL_W-1:0] wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output logic      [fcc_pkg::VAL_W-1:0] rd_data
);
   import fcc_pkg::*;

   logic [VAL_W-1:0] mem [TABLE_ENTRIES];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/fcc_ctrl.sv =====
// fcc_ctrl: command sequencer; writes, reads, scans, links and clears table entries.
// Depends on fcc_pkg; drives the ports of fcc_table.
`default_nettype none

module fcc_ctrl #(
   parameter int TABLE_ENTRIES = fcc_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int AW = $clog2(TABLE_ENTRIES)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [fcc_pkg::CNT_W-1:0] lim,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [1:0]                req_cmd,
   input  wire logic [fcc_pkg::IDX_W-1:0] req_index,
   input  wire logic [fcc_pkg::VAL_W-1:0] req_entry_value,
   input  wire logic [fcc_pkg::CNT_W-1:0] req_cluster_count,
   output logic                           res_valid,
   input  wire logic                      res_take,
   output fcc_pkg::result_type            res,
   output logic                           mem_wr_en,
   output logic [AW-1:0]                  mem_wr_addr,
   output logic [fcc_pkg::VAL_W-1:0]      mem_wr_data,
   output logic                           mem_rd_en,
   output logic [AW-1:0]                  mem_rd_addr,
   input  wire logic [fcc_pkg::VAL_W-1:0] mem_rd_data
);
   import fcc_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] paddr_ff, paddr_in;
   logic [CNT_W-1:0] found_ff, found_in;
   logic [CNT_W-1:0] want_ff, want_in;
   logic [CNT_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   result_type       res_ff, res_in;

   logic             idx_ok;
   logic             hit;
   logic             last_hit;
   logic             data_end;
   logic             data_out;
   logic [VAL_W-1:0] lim_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      pend_ff  <= pend_in;
      paddr_ff <= paddr_in;
      found_ff <= found_in;
      want_ff  <= want_in;
      first_ff <= first_in;
      prev_ff  <= prev_in;
      start_ff <= start_in;
      steps_ff <= steps_in;
      res_ff   <= res_in;
   end

   always_comb begin
      lim_wide = VAL_W'(lim);
      idx_ok   = CNT_W'(req_index) < lim;
      hit      = pend_ff && (mem_rd_data == FREE_MARK);
      last_hit = hit && ((found_ff + 1'b1) == want_ff);
      data_end = mem_rd_data >= CHAIN_LIMIT;
      data_out = (mem_rd_data >= lim_wide) || (steps_ff >= lim);

      state_in    = state_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      paddr_in    = paddr_ff;
      found_in    = found_ff;
      want_in     = want_ff;
      first_in    = first_ff;
      prev_in     = prev_ff;
      start_in    = start_ff;
      steps_in    = steps_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               want_in  = req_cluster_count;
               start_in = req_index;
               res_in   = '{value: '0, count: '0, status: ST_OK};
               case (cmd_type'(req_cmd))
                  CMD_WRITE: begin
                     if (idx_ok) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(req_index);
                        mem_wr_data = req_entry_value;
                     end else begin
                        res_in.status = ST_BAD_INDEX;
                     end
                     state_in = S_DONE;
                  end
                  CMD_READ: begin
                     if (idx_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req_index);
                        state_in    = S_READ;
                     end else begin
                        res_in.status = ST_BAD_INDEX;
                        state_in      = S_DONE;
                     end
                  end
                  CMD_ALLOC: begin
                     if (req_cluster_count == '0) begin
                        res_in.status = ST_ZERO_COUNT;
                        state_in      = S_DONE;
                     end else begin
                        scan_in  = '0;
                        found_in = '0;
                        pend_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (idx_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req_index);
                        paddr_in    = CNT_W'(req_index);
                        steps_in    = CNT_W'(1);
                        state_in    = S_CHECK;
                     end else begin
                        res_in.status = ST_BAD_INDEX;
                        state_in      = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            res_in   = '{value: mem_rd_data, count: '0, status: ST_OK};
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (hit) begin
               found_in = found_ff + 1'b1;
               if (found_ff == '0) begin
                  first_in = paddr_ff;
               end
            end
            if (last_hit) begin
               scan_in  = (found_ff == '0) ? paddr_ff : first_ff;
               found_in = '0;
               pend_in  = 1'b0;
               state_in = S_LINK;
            end else if (scan_ff < lim) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(scan_ff);
               pend_in     = 1'b1;
               paddr_in    = scan_ff;
               scan_in     = scan_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_in   = '{value: '0, count: '0, status: ST_NO_SPACE};
                  state_in = S_DONE;
               end
            end
         end
         S_LINK: begin
            if (hit) begin
               if (found_ff != '0) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = AW'(prev_ff);
                  mem_wr_data = VAL_W'(paddr_ff);
               end
               prev_in  = paddr_ff;
               found_in = found_ff + 1'b1;
            end
            if (last_hit) begin
               pend_in  = 1'b0;
               state_in = S_TAIL;
            end else if (scan_ff < lim) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(scan_ff);
               pend_in     = 1'b1;
               paddr_in    = scan_ff;
               scan_in     = scan_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_TAIL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(prev_ff);
            mem_wr_data = END_OF_CHAIN;
            res_in      = '{value: VAL_W'(first_ff), count: want_ff, status: ST_OK};
            state_in    = S_DONE;
         end
         S_CHECK: begin
            if (data_end) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(start_ff);
               paddr_in    = CNT_W'(start_ff);
               state_in    = S_CLEAR;
            end else if (data_out) begin
               res_in   = '{value: '0, count: '0, status: ST_BROKEN};
               state_in = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(mem_rd_data);
               paddr_in    = CNT_W'(mem_rd_data);
               steps_in    = steps_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(paddr_ff);
            mem_wr_data = FREE_MARK;
            if (data_end) begin
               res_in   = '{value: '0, count: steps_ff, status: ST_OK};
               state_in = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(mem_rd_data);
               paddr_in    = CNT_W'(mem_rd_data);
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule

`default_nettype wire
